// ===== rtl/emf_pkg.sv =====
// Shared widths, constants, command and status types for the moving average filter.
// Used by emf_ctrl, emf_datapath and ema_filter_with_rate_and_extrema.
`default_nettype none
package emf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIFF_BITS = WORD_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + COEF_BITS + 1;
    localparam int SAT_IN_BITS = (SAMPLE_BITS + FRAC_BITS + 1 > DIFF_BITS) ?
                                 SAMPLE_BITS + FRAC_BITS + 1 : DIFF_BITS;

    localparam int K_BASE = 58982;
    localparam logic [COEF_BITS-1:0] K_RESET = (COEF_BITS >= 16) ?
        COEF_BITS'(K_BASE << (COEF_BITS - 16)) : COEF_BITS'(K_BASE >> (16 - COEF_BITS));
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(64'd1 << (COEF_BITS - 1));

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [1:0] SEL_AVG    = 2'd0;
    localparam logic [1:0] SEL_PEAK   = 2'd1;
    localparam logic [1:0] SEL_VALLEY = 2'd2;

    typedef struct packed {
        logic       load;
        logic       init_avg;
        logic       diff_en;
        logic       mul_en;
        logic       upd_en;
        logic       rate_en;
        logic       out_load;
        logic [1:0] sel;
    } emf_cmd_t;

    typedef struct packed {
        logic fresh;
    } emf_status_t;

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [SAT_IN_BITS-1:0] v);
        logic [SAT_IN_BITS-WORD_BITS:0] upper;
        upper = v[SAT_IN_BITS-1:WORD_BITS-1];
        if ((&upper) || (~|upper))
            return v[WORD_BITS-1:0];
        else if (v[SAT_IN_BITS-1])
            return WORD_MIN;
        else
            return WORD_MAX;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ema_filter_with_rate_and_extrema.sv =====
// Top level of the moving average filter with rate and decaying extrema.
// Holds the coefficient register and joins emf_ctrl and emf_datapath; uses emf_pkg.
//
//   channel   direction  handshake                     payload
//   item      input      item_valid / item_stall       sample, restart
//   result    output     result_valid / result_stall   average_out, rate_out, peak_out,
//                                                      valley_out
//   config    input      psel / penable / pwrite       paddr, pwdata, prdata
//
// An item runs from acceptance to a loaded result, by a shorter path when it only loads
// the average; one shared multiplier works through the average, peak and valley blends
// in turn. The next item is accepted the cycle after the result register is loaded.
// Reset is asynchronous and clears the state to its start values and the coefficient
// to its default. A stalled result holds the sequence in its last step.
`default_nettype none
module ema_filter_with_rate_and_extrema (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   item_valid,
    output logic                                  item_stall,
    input  wire signed [emf_pkg::SAMPLE_BITS-1:0] sample,
    input  wire                                   restart,
    output logic                                  result_valid,
    input  wire                                   result_stall,
    output logic signed [emf_pkg::WORD_BITS-1:0]  average_out,
    output logic signed [emf_pkg::WORD_BITS-1:0]  rate_out,
    output logic signed [emf_pkg::WORD_BITS-1:0]  peak_out,
    output logic signed [emf_pkg::WORD_BITS-1:0]  valley_out,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire        [2:0]                      paddr,
    input  wire        [31:0]                     pwdata,
    output logic       [31:0]                     prdata,
    output logic                                  pready
);
    import emf_pkg::*;

    logic [COEF_BITS-1:0] coef_reg, coef_next;
    emf_cmd_t             cmd;
    emf_status_t          status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-COEF_BITS){1'b0}}, coef_reg} : 32'd0;

    always_comb
    begin
        coef_next = coef_reg;
        if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            coef_next = pwdata[COEF_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= K_RESET;
        else
            coef_reg <= coef_next;
    end

    emf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    emf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .coef        (coef_reg),
        .sample      (sample),
        .restart     (restart),
        .average_out (average_out),
        .rate_out    (rate_out),
        .peak_out    (peak_out),
        .valley_out  (valley_out)
    );

endmodule
`default_nettype wire

// ===== rtl/emf_ctrl.sv =====
// Sequencing state machine for the moving average filter.
// Depends on emf_pkg for the command and status types.
`default_nettype none
module emf_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    output logic                 result_valid,
    input  wire                  result_stall,
    input  emf_pkg::emf_status_t status,
    output emf_pkg::emf_cmd_t    cmd
);
    import emf_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_AVG_MUL  = 4'd2;
    localparam logic [3:0] S_AVG_UPD  = 4'd3;
    localparam logic [3:0] S_PK_DIFF  = 4'd4;
    localparam logic [3:0] S_PK_MUL   = 4'd5;
    localparam logic [3:0] S_PK_UPD   = 4'd6;
    localparam logic [3:0] S_VL_DIFF  = 4'd7;
    localparam logic [3:0] S_VL_MUL   = 4'd8;
    localparam logic [3:0] S_VL_UPD   = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_AVG;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.fresh)
                begin
                    cmd.init_avg = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.diff_en = 1'b1;
                    state_next  = S_AVG_MUL;
                end
            end
            S_AVG_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_AVG_UPD;
            end
            S_AVG_UPD:
            begin
                cmd.upd_en = 1'b1;
                state_next = S_PK_DIFF;
            end
            S_PK_DIFF:
            begin
                cmd.sel     = SEL_PEAK;
                cmd.diff_en = 1'b1;
                cmd.rate_en = 1'b1;
                state_next  = S_PK_MUL;
            end
            S_PK_MUL:
            begin
                cmd.sel    = SEL_PEAK;
                cmd.mul_en = 1'b1;
                state_next = S_PK_UPD;
            end
            S_PK_UPD:
            begin
                cmd.sel    = SEL_PEAK;
                cmd.upd_en = 1'b1;
                state_next = S_VL_DIFF;
            end
            S_VL_DIFF:
            begin
                cmd.sel     = SEL_VALLEY;
                cmd.diff_en = 1'b1;
                state_next  = S_VL_MUL;
            end
            S_VL_MUL:
            begin
                cmd.sel    = SEL_VALLEY;
                cmd.mul_en = 1'b1;
                state_next = S_VL_UPD;
            end
            S_VL_UPD:
            begin
                cmd.sel    = SEL_VALLEY;
                cmd.upd_en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!valid_reg || !result_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(valid_reg && result_stall))
        else $error("result register overwritten while a transfer is pending");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == S_CHECK))
        else $error("accepted transfer did not start the sequence");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result became valid outside the final step");
`endif

endmodule
`default_nettype wire

// ===== rtl/emf_datapath.sv =====
// State registers, shared blend multiplier and result register of the filter.
// Depends on emf_pkg for widths, constants and the command and status types.
`default_nettype none
module emf_datapath (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  emf_pkg::emf_cmd_t                        cmd,
    output emf_pkg::emf_status_t                     status,
    input  wire        [emf_pkg::COEF_BITS-1:0]      coef,
    input  wire signed [emf_pkg::SAMPLE_BITS-1:0]    sample,
    input  wire                                      restart,
    output logic signed [emf_pkg::WORD_BITS-1:0]     average_out,
    output logic signed [emf_pkg::WORD_BITS-1:0]     rate_out,
    output logic signed [emf_pkg::WORD_BITS-1:0]     peak_out,
    output logic signed [emf_pkg::WORD_BITS-1:0]     valley_out
);
    import emf_pkg::*;

    logic        [SAMPLE_BITS-1:0] prev_reg;
    logic        [SAMPLE_BITS-1:0] raw_reg;
    logic signed [WORD_BITS-1:0]   x_reg;
    logic signed [WORD_BITS-1:0]   avg_reg;
    logic signed [WORD_BITS-1:0]   old_avg_reg;
    logic signed [WORD_BITS-1:0]   chg_reg;
    logic signed [WORD_BITS-1:0]   peak_reg;
    logic signed [WORD_BITS-1:0]   valley_reg;
    logic signed [DIFF_BITS-1:0]   diff_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;

    logic signed [SAT_IN_BITS-1:0] sample_wide;
    logic signed [WORD_BITS-1:0]   x_next;
    logic signed [WORD_BITS-1:0]   diff_a;
    logic signed [WORD_BITS-1:0]   diff_b;
    logic signed [PROD_BITS-1:0]   rounded;
    logic signed [PROD_BITS-1:0]   shifted;
    logic signed [DIFF_BITS:0]     blend_sum;
    logic signed [WORD_BITS-1:0]   target;
    logic signed [WORD_BITS-1:0]   blend;
    logic signed [SAT_IN_BITS-1:0] rate_wide;

    assign sample_wide = {{(SAT_IN_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    assign x_next      = sat_word(sample_wide <<< FRAC_BITS);

    assign status.fresh = (prev_reg == '0) && (avg_reg == '0) && (chg_reg == '0);

    always_comb
    begin
        case (cmd.sel)
            SEL_PEAK:
            begin
                diff_a = peak_reg;
                diff_b = avg_reg;
                target = avg_reg;
            end
            SEL_VALLEY:
            begin
                diff_a = valley_reg;
                diff_b = avg_reg;
                target = avg_reg;
            end
            default:
            begin
                diff_a = avg_reg;
                diff_b = x_reg;
                target = x_reg;
            end
        endcase
    end

    assign rounded   = prod_reg + ROUND_HALF;
    assign shifted   = rounded >>> COEF_BITS;
    assign blend_sum = shifted[DIFF_BITS:0] + {{2{target[WORD_BITS-1]}}, target};
    assign blend     = blend_sum[WORD_BITS-1:0];
    assign rate_wide = SAT_IN_BITS'(avg_reg) - SAT_IN_BITS'(old_avg_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg <= sample;
            x_reg   <= x_next;
        end
        if (cmd.diff_en)
            diff_reg <= DIFF_BITS'(diff_a) - DIFF_BITS'(diff_b);
        if (cmd.mul_en)
            prod_reg <= diff_reg * $signed({1'b0, coef});
        if (cmd.upd_en && cmd.sel == SEL_AVG)
            old_avg_reg <= avg_reg;
        if (cmd.out_load)
        begin
            average_out <= avg_reg;
            rate_out    <= chg_reg;
            peak_out    <= peak_reg;
            valley_out  <= valley_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            avg_reg    <= '0;
            chg_reg    <= '0;
            peak_reg   <= WORD_MIN;
            valley_reg <= WORD_MAX;
        end
        else
        begin
            if (cmd.load && restart)
            begin
                prev_reg   <= '0;
                avg_reg    <= '0;
                chg_reg    <= '0;
                peak_reg   <= WORD_MIN;
                valley_reg <= WORD_MAX;
            end
            if (cmd.init_avg)
                avg_reg <= x_reg;
            if (cmd.rate_en)
                chg_reg <= sat_word(rate_wide);
            if (cmd.upd_en)
            begin
                case (cmd.sel)
                    SEL_PEAK:
                        peak_reg <= (peak_reg < x_reg) ? x_reg : blend;
                    SEL_VALLEY:
                        valley_reg <= (x_reg < valley_reg) ? x_reg : blend;
                    default:
                        avg_reg <= blend;
                endcase
            end
            if (cmd.out_load)
                prev_reg <= raw_reg;
        end
    end

endmodule
`default_nettype wire
